// File: rtl/core/mrw_pkg.sv
// Package for the Miller-Rabin witness round: operand width, counter width,
// product selector codes and the command and status words between the controller and datapath.
// No dependencies.
package mrw_pkg;

   localparam int NUM_WIDTH = 63;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
   localparam int EXT_WIDTH = NUM_WIDTH + 3;

   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [CNT_WIDTH-1:0] cnt_type;
   typedef logic [EXT_WIDTH-1:0] ext_type;

   typedef enum logic [1:0] {
      MUL_REDUCE,
      MUL_XB,
      MUL_BB,
      MUL_XX
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       strip;
      logic       mul_start;
      mul_op_type mul_op;
      logic       d_shift;
      logic       sq_init;
      logic       sq_inc;
   } ctrl_cmd_type;

   typedef struct packed {
      logic invalid;
      logic d_lsb;
      logic d_zero;
      logic x_is_one;
      logic x_is_n1;
      logic sq_more;
      logic mul_done;
   } dp_status_type;

endpackage

// File: rtl/core/mrw_modmul.sv
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
// Depends on mrw_pkg.
module mrw_modmul (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mrw_pkg::num_type multiplicand,
   input  mrw_pkg::num_type multiplier,
   input  mrw_pkg::num_type modulus,
   output logic             done,
   output mrw_pkg::num_type product
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   mrw_pkg::cnt_type count_ff, count_in;
   mrw_pkg::num_type y_ff, y_in;
   mrw_pkg::num_type acc_ff, acc_in;
   mrw_pkg::ext_type addx0_ff, addx0_in;
   mrw_pkg::ext_type addx1_ff, addx1_in;
   mrw_pkg::ext_type addx2_ff, addx2_in;
   mrw_pkg::ext_type negn_ff, negn_in;
   mrw_pkg::ext_type neg2n_ff, neg2n_in;

   mrw_pkg::ext_type ext_x, ext_m, ext_2m, dbl, sel0, sel1, sel2, v0, v1, v2;
   mrw_pkg::num_type step_acc;
   logic             ybit;

   assign ext_x  = {3'b000, multiplicand};
   assign ext_m  = {3'b000, modulus};
   assign ext_2m = {2'b00, modulus, 1'b0};

   assign ybit = y_ff[mrw_pkg::NUM_WIDTH-1];
   assign dbl  = {2'b00, acc_ff, 1'b0};
   assign sel0 = ybit ? addx0_ff : '0;
   assign sel1 = ybit ? addx1_ff : negn_ff;
   assign sel2 = ybit ? addx2_ff : neg2n_ff;
   assign v0   = dbl + sel0;
   assign v1   = dbl + sel1;
   assign v2   = dbl + sel2;

   always_comb begin
      if (!v2[mrw_pkg::EXT_WIDTH-1]) begin
         step_acc = v2[mrw_pkg::NUM_WIDTH-1:0];
      end else if (!v1[mrw_pkg::EXT_WIDTH-1]) begin
         step_acc = v1[mrw_pkg::NUM_WIDTH-1:0];
      end else begin
         step_acc = v0[mrw_pkg::NUM_WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      addx0_in = addx0_ff;
      addx1_in = addx1_ff;
      addx2_in = addx2_ff;
      negn_in  = negn_ff;
      neg2n_in = neg2n_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = mrw_pkg::cnt_type'(mrw_pkg::NUM_WIDTH - 1);
         y_in     = multiplier;
         acc_in   = '0;
         addx0_in = ext_x;
         addx1_in = ext_x - ext_m;
         addx2_in = ext_x - ext_2m;
         negn_in  = '0 - ext_m;
         neg2n_in = '0 - ext_2m;
      end else if (busy_ff) begin
         acc_in = step_acc;
         y_in   = {y_ff[mrw_pkg::NUM_WIDTH-2:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      addx0_ff <= addx0_in;
      addx1_ff <= addx1_in;
      addx2_ff <= addx2_in;
      negn_ff  <= negn_in;
      neg2n_ff <= neg2n_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/core/mrw_datapath.sv
// Datapath of the witness round: operand, exponent, power and counter registers
// around the modular multiplier. Depends on mrw_pkg and mrw_modmul.
module mrw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mrw_pkg::ctrl_cmd_type cmd,
   input  mrw_pkg::num_type      req_modulus,
   input  mrw_pkg::num_type      req_witness,
   output mrw_pkg::dp_status_type status
);

   mrw_pkg::num_type   n_ff, n_in;
   mrw_pkg::num_type   a_ff, a_in;
   mrw_pkg::num_type   n1_ff, n1_in;
   mrw_pkg::num_type   d_ff, d_in;
   mrw_pkg::num_type   x_ff, x_in;
   mrw_pkg::num_type   base_ff, base_in;
   mrw_pkg::cnt_type   s_ff, s_in;
   mrw_pkg::cnt_type   i_ff, i_in;
   mrw_pkg::mul_op_type op_ff, op_in;

   mrw_pkg::num_type mul_x, mul_y, product;
   logic             mul_done;

   always_comb begin
      case (cmd.mul_op)
         mrw_pkg::MUL_REDUCE: begin
            mul_x = mrw_pkg::num_type'(1);
            mul_y = a_ff;
         end
         mrw_pkg::MUL_XB: begin
            mul_x = x_ff;
            mul_y = base_ff;
         end
         mrw_pkg::MUL_BB: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
         default: begin
            mul_x = x_ff;
            mul_y = x_ff;
         end
      endcase
   end

   mrw_modmul u_modmul (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.mul_start),
      .multiplicand (mul_x),
      .multiplier   (mul_y),
      .modulus      (n_ff),
      .done         (mul_done),
      .product      (product)
   );

   always_comb begin
      n_in    = n_ff;
      a_in    = a_ff;
      n1_in   = n1_ff;
      d_in    = d_ff;
      x_in    = x_ff;
      base_in = base_ff;
      s_in    = s_ff;
      i_in    = i_ff;
      op_in   = op_ff;
      if (cmd.load) begin
         n_in = req_modulus;
         a_in = req_witness;
      end
      if (cmd.init) begin
         n1_in = n_ff - 1'b1;
         d_in  = n_ff - 1'b1;
         s_in  = '0;
         i_in  = mrw_pkg::cnt_type'(1);
         x_in  = mrw_pkg::num_type'(1);
      end
      if (cmd.strip) begin
         d_in = d_ff >> 1;
         s_in = s_ff + 1'b1;
      end
      if (cmd.d_shift) begin
         d_in = d_ff >> 1;
      end
      if (cmd.sq_init) begin
         i_in = mrw_pkg::cnt_type'(1);
      end
      if (cmd.sq_inc) begin
         i_in = i_ff + 1'b1;
      end
      if (mul_done) begin
         case (op_ff)
            mrw_pkg::MUL_REDUCE, mrw_pkg::MUL_BB: begin
               base_in = product;
            end
            default: begin
               x_in = product;
            end
         endcase
      end
      if (cmd.mul_start) begin
         op_in = cmd.mul_op;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      a_ff    <= a_in;
      n1_ff   <= n1_in;
      d_ff    <= d_in;
      x_ff    <= x_in;
      base_ff <= base_in;
      s_ff    <= s_in;
      i_ff    <= i_in;
      op_ff   <= op_in;
   end

   assign status.invalid  = (n_ff < mrw_pkg::num_type'(3)) || !n_ff[0];
   assign status.d_lsb    = d_ff[0];
   assign status.d_zero   = (d_ff == '0);
   assign status.x_is_one = (x_ff == mrw_pkg::num_type'(1));
   assign status.x_is_n1  = (x_ff == n1_ff);
   assign status.sq_more  = (i_ff < s_ff);
   assign status.mul_done = mul_done;

endmodule

// File: rtl/core/mrw_ctrl.sv
// Controller of the witness round: sequences exponent stripping, square-and-multiply
// and the final squarings, and registers the result word. Depends on mrw_pkg.
module mrw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mrw_pkg::dp_status_type status,
   output mrw_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic                   rsp_probable_prime,
   output logic                   rsp_invalid_modulus
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STRIP,
      ST_REDUCE,
      ST_LOOP,
      ST_MUL_XB,
      ST_MUL_BB,
      ST_VERIFY,
      ST_SQUARE,
      ST_SQ_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      prime_ff, prime_in;
   logic      invalid_ff, invalid_in;

   always_comb begin
      state_in   = state_ff;
      valid_in   = 1'b0;
      prime_in   = prime_ff;
      invalid_in = invalid_ff;
      cmd        = '0;
      cmd.mul_op = mrw_pkg::MUL_REDUCE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.invalid) begin
               valid_in   = 1'b1;
               prime_in   = 1'b0;
               invalid_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.init = 1'b1;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (!status.d_lsb) begin
               cmd.strip = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = mrw_pkg::MUL_REDUCE;
               state_in      = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.mul_done) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            cmd.mul_start = !status.d_zero;
            if (status.d_zero) begin
               state_in = ST_VERIFY;
            end else if (status.d_lsb) begin
               cmd.mul_op = mrw_pkg::MUL_XB;
               state_in   = ST_MUL_XB;
            end else begin
               cmd.mul_op = mrw_pkg::MUL_BB;
               state_in   = ST_MUL_BB;
            end
         end
         ST_MUL_XB: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = mrw_pkg::MUL_BB;
               state_in      = ST_MUL_BB;
            end
         end
         ST_MUL_BB: begin
            if (status.mul_done) begin
               cmd.d_shift = 1'b1;
               state_in    = ST_LOOP;
            end
         end
         ST_VERIFY: begin
            cmd.sq_init = 1'b1;
            if (status.x_is_one || status.x_is_n1) begin
               valid_in   = 1'b1;
               prime_in   = 1'b1;
               invalid_in = 1'b0;
               state_in   = ST_IDLE;
            end else if (!status.sq_more) begin
               valid_in   = 1'b1;
               prime_in   = 1'b0;
               invalid_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = mrw_pkg::MUL_XX;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.mul_done) begin
               cmd.sq_inc = 1'b1;
               state_in   = ST_SQ_CHECK;
            end
         end
         ST_SQ_CHECK: begin
            if (status.x_is_n1) begin
               valid_in   = 1'b1;
               prime_in   = 1'b1;
               invalid_in = 1'b0;
               state_in   = ST_IDLE;
            end else if (!status.sq_more) begin
               valid_in   = 1'b1;
               prime_in   = 1'b0;
               invalid_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = mrw_pkg::MUL_XX;
               state_in      = ST_SQUARE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         prime_ff   <= 1'b0;
         invalid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         prime_ff   <= prime_in;
         invalid_ff <= invalid_in;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = valid_ff;
   assign rsp_probable_prime  = prime_ff;
   assign rsp_invalid_modulus = invalid_ff;

endmodule

// File: rtl/core/miller_rabin_witness_round.sv
// Top level of the Miller-Rabin single-witness round: controller plus datapath.
// Depends on mrw_pkg, mrw_ctrl and mrw_datapath.
//
//   channel   | handshake          | word
//   ----------+--------------------+------------------------------------------
//   request   | start, busy        | req_modulus, req_witness
//   response  | rsp_valid (strobe) | rsp_probable_prime, rsp_invalid_modulus
//
// An invalid modulus is answered from the check state, once the operands are
// loaded. Otherwise each word takes one strip step per factor of two in
// modulus minus one and a series of modular products in the shift-add
// multiplier: one product for the witness reduction, one square per exponent
// bit, one multiply per set exponent bit and one per final squaring.
// Synchronous reset returns the controller to idle. The response strobe lasts
// one cycle and cannot be stalled; busy is low again in that same cycle.
module miller_rabin_witness_round (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mrw_pkg::num_type req_modulus,
   input  mrw_pkg::num_type req_witness,
   output logic             rsp_valid,
   output logic             rsp_probable_prime,
   output logic             rsp_invalid_modulus
);

   mrw_pkg::ctrl_cmd_type  cmd;
   mrw_pkg::dp_status_type status;

   mrw_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .status              (status),
      .cmd                 (cmd),
      .busy                (busy),
      .rsp_valid           (rsp_valid),
      .rsp_probable_prime  (rsp_probable_prime),
      .rsp_invalid_modulus (rsp_invalid_modulus)
   );

   mrw_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_modulus (req_modulus),
      .req_witness (req_witness),
      .status      (status)
   );

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response strobe without a preceding busy cycle");

   a_invalid_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid_modulus |-> !rsp_probable_prime)
      else $error("invalid modulus reported as probable prime");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

endmodule

// File: tb/miller_rabin_witness_round_tb.sv
// Testbench for miller_rabin_witness_round: directed words, then random words, each checked
// against its typed verdict or a behavioral single-witness strong pseudoprime predictor.
// Depends on mrw_pkg and the RTL of miller_rabin_witness_round.
`timescale 1ns / 100ps

module miller_rabin_witness_round_tb;

   typedef mrw_pkg::num_type num_type;

   typedef struct packed {
      logic probable_prime;
      logic invalid_modulus;
   } verdict_type;

   typedef struct {
      num_type     modulus;
      num_type     witness;
      bit          typed;
      verdict_type verdict;
   } stim_row_type;

   localparam verdict_type V_INVALID   = '{1'b0, 1'b1};
   localparam verdict_type V_COMPOSITE = '{1'b0, 1'b0};
   localparam verdict_type V_PASS      = '{1'b1, 1'b0};

   localparam int      NUM_WIDTH    = mrw_pkg::NUM_WIDTH;
   localparam int      NUM_DIRECTED = 22;
   localparam int      NUM_RANDOM   = 78;
   localparam longint  CYCLE_LIMIT  = 10_000_000;
   localparam num_type ALL_ONES     = {NUM_WIDTH{1'b1}};
   localparam num_type PRIME_63     = 63'h7FFF_FFFF_FFFF_FFE7;
   localparam num_type PRIME_62     = 63'h3FFF_FFFF_FFFF_FFC7;
   localparam num_type PRIME_61     = 63'h1FFF_FFFF_FFFF_FFFF;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   num_type req_modulus;
   num_type req_witness;
   logic    rsp_valid;
   logic    rsp_probable_prime;
   logic    rsp_invalid_modulus;

   verdict_type verdict_q[$];
   longint      cycles;
   int          mismatches;
   int          words_sent;
   int          invalid_sent;
   int          wide_sent;
   int          words_seen;
   int          passes_seen;
   int          burst_left;

   stim_row_type dir_rows [0:NUM_DIRECTED-1] = '{
      '{63'd0, 63'd0, 1'b1, V_INVALID},
      '{63'd1, ALL_ONES, 1'b1, V_INVALID},
      '{63'd2, 63'd5, 1'b1, V_INVALID},
      '{63'h7FFF_FFFF_FFFF_FFFE, 63'd3, 1'b1, V_INVALID},
      '{63'h4000_0000_0000_0000, ALL_ONES, 1'b1, V_INVALID},
      '{63'd3, 63'd2, 1'b0, V_PASS},
      '{63'd3, 63'd0, 1'b1, V_COMPOSITE},
      '{63'd3, 63'd6, 1'b1, V_COMPOSITE},
      '{63'd5, 63'd10, 1'b1, V_COMPOSITE},
      '{63'd97, 63'd1, 1'b1, V_PASS},
      '{63'd97, 63'd96, 1'b1, V_PASS},
      '{63'd97, ALL_ONES, 1'b0, V_PASS},
      '{63'd561, 63'd2, 1'b0, V_PASS},
      '{63'd2047, 63'd2, 1'b0, V_PASS},
      '{63'd3215031751, 63'd7, 1'b0, V_PASS},
      '{PRIME_61, 63'd3, 1'b0, V_PASS},
      '{PRIME_63, ALL_ONES, 1'b0, V_PASS},
      '{PRIME_63, PRIME_63 - 63'd1, 1'b1, V_PASS},
      '{ALL_ONES, 63'd2, 1'b0, V_PASS},
      '{63'h4000_0000_0000_0001, 63'd3, 1'b0, V_PASS},
      '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, V_PASS},
      '{PRIME_62, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, V_PASS}
   };

   miller_rabin_witness_round u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_modulus         (req_modulus),
      .req_witness         (req_witness),
      .rsp_valid           (rsp_valid),
      .rsp_probable_prime  (rsp_probable_prime),
      .rsp_invalid_modulus (rsp_invalid_modulus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic num_type mod_product(num_type x, num_type y, num_type m);
      logic [2*NUM_WIDTH-1:0] p;
      p = {{NUM_WIDTH{1'b0}}, x} * {{NUM_WIDTH{1'b0}}, y};
      return num_type'(p % {{NUM_WIDTH{1'b0}}, m});
   endfunction

   function automatic verdict_type miller_rabin_verdict(num_type n, num_type a);
      num_type d;
      num_type x;
      num_type base;
      num_type n1;
      int      s;
      bit      pass;
      if (n < 3 || n[0] == 1'b0) return V_INVALID;
      n1 = n - 1;
      d = n1;
      s = 0;
      while (d[0] == 1'b0) begin
         d = d >> 1;
         s++;
      end
      base = a % n;
      x = 1;
      while (d != 0) begin
         if (d[0]) x = mod_product(x, base, n);
         base = mod_product(base, base, n);
         d = d >> 1;
      end
      pass = (x == 1) || (x == n1);
      for (int i = 1; !pass && i < s; i++) begin
         x = mod_product(x, x, n);
         if (x == n1) pass = 1'b1;
      end
      return pass ? V_PASS : V_COMPOSITE;
   endfunction

   function automatic bit is_small_prime(longint unsigned v);
      if (v < 2) return 1'b0;
      if (v % 2 == 0) return v == 2;
      for (longint unsigned f = 3; f * f <= v; f += 2) begin
         if (v % f == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic num_type rand_num();
      return num_type'({$urandom, $urandom});
   endfunction

   function automatic num_type rand_bits(int bits);
      return rand_num() >> (NUM_WIDTH - bits);
   endfunction

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 7);
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
   endfunction

   task automatic pick_random_word(output num_type n, output num_type w);
      int          kind;
      int          bits;
      longint unsigned small_n;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         case ($urandom_range(0, 2))
            0: n = num_type'($urandom_range(0, 2));
            1: n = rand_num() & ~num_type'(1);
            default: n = rand_bits($urandom_range(2, 20)) & ~num_type'(1);
         endcase
         w = rand_num();
      end else if (kind < 14) begin
         case ($urandom_range(0, 3))
            0: n = PRIME_63;
            1: n = PRIME_62;
            2: n = PRIME_61;
            default: n = rand_num() | {1'b1, {(NUM_WIDTH-2){1'b0}}, 1'b1};
         endcase
         w = ($urandom_range(0, 4) == 0) ? rand_num() : (rand_num() % (n - 3)) + 2;
      end else begin
         bits = $urandom_range(2, 20);
         small_n = longint'(rand_bits(bits)) | 64'd1 | (64'd1 << (bits - 1));
         if ($urandom_range(0, 1) == 0) begin
            while (!is_small_prime(small_n)) small_n += 2;
         end
         n = num_type'(small_n);
         case ($urandom_range(0, 19))
            0, 1, 2: w = rand_num();
            3, 4: w = n * num_type'($urandom_range(0, 5));
            5: w = n - 1;
            6: w = 1;
            default: w = (n > 4) ? (num_type'($urandom) % (n - 3)) + 2 : num_type'($urandom);
         endcase
      end
   endtask

   task automatic drive_word(num_type n, num_type w, verdict_type want, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_modulus <= n;
      req_witness <= w;
      do @(posedge clock); while (busy);
      verdict_q.push_back(want);
      words_sent++;
      if (want == V_INVALID) invalid_sent++;
      if (n[NUM_WIDTH-1]) wide_sent++;
   endtask

   task automatic report_word(string what, verdict_type want, verdict_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: prime exp %0b got %0b, invalid exp %0b got %0b", $realtime, what,
                  want.probable_prime, got.probable_prime,
                  want.invalid_modulus, got.invalid_modulus);
      end
   endtask

   always @(posedge clock) begin : check_words
      verdict_type got;
      verdict_type want;
      cycles++;
      if (!reset && rsp_valid) begin
         got = '{rsp_probable_prime, rsp_invalid_modulus};
         words_seen++;
         if (got.probable_prime) passes_seen++;
         if (verdict_q.size() == 0) begin
            report_word("unexpected word", '0, got);
         end else begin
            want = verdict_q.pop_front();
            if (got.probable_prime !== want.probable_prime ||
                got.invalid_modulus !== want.invalid_modulus) begin
               report_word("wrong word", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding", cycles,
                  verdict_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      num_type     n;
      num_type     w;
      verdict_type want;
      cycles = 0;
      mismatches = 0;
      words_sent = 0;
      invalid_sent = 0;
      wide_sent = 0;
      words_seen = 0;
      passes_seen = 0;
      burst_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_modulus = '0;
      req_witness = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         want = dir_rows[i].typed ? dir_rows[i].verdict
                                  : miller_rabin_verdict(dir_rows[i].modulus,
                                                         dir_rows[i].witness);
         drive_word(dir_rows[i].modulus, dir_rows[i].witness, want, next_gap());
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         pick_random_word(n, w);
         drive_word(n, w, miller_rabin_verdict(n, w), next_gap());
      end
      @(negedge clock);
      start <= 1'b0;
      wait (verdict_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d words (%0d with an invalid modulus, %0d with a 63-bit modulus).",
               words_sent, invalid_sent, wide_sent);
      $display("Checked %0d result words, %0d of them probable prime, in %0d cycles.",
               words_seen, passes_seen, cycles);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
